### rtl/mfbosd_pkg.sv
// Shared types, sizes and codes for the monochrome frame store with scan-out.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package mfbosd_pkg;

   // Frame geometry and derived store sizes.
   localparam int FRAME_WIDTH  = 256;
   localparam int FRAME_HEIGHT = 256;
   localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
   localparam int STORE_BYTES  = ROW_BYTES * FRAME_HEIGHT;
   localparam int ADDR_W       = $clog2(STORE_BYTES);
   localparam int MAX_RESULTS  = 32;
   localparam int SCAN_N       = (ROW_BYTES < MAX_RESULTS) ? ROW_BYTES : MAX_RESULTS;
   localparam int K_W          = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

   // Field widths.
   localparam int COORD_W = 16;
   localparam int SIZE_W  = 16;
   localparam int RUN_W   = SIZE_W - 2;
   localparam int LIN_W   = 24;
   localparam int LINE_W  = 10;
   localparam int LCNT_W  = 16;
   localparam int ROW_W   = 8;
   localparam int PIX_W   = 8;

   // Command queue between the front and back halves.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Port widths.
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [LINE_W-1:0] FIRST_LINE_RST = LINE_W'(27);
   localparam logic [LINE_W-1:0] LAST_LINE_RST  = LINE_W'(302);
   localparam logic [PIX_W-1:0]  BYTE_ONES      = 8'hFF;
   localparam logic [PIX_W-1:0]  MSB_MASK       = 8'h80;

   typedef enum logic [1:0] {
      CMD_PIXEL = 2'd0,
      CMD_FILL  = 2'd1,
      CMD_CSYNC = 2'd2,
      CMD_VSYNC = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROTATION   = 3'd0,
      CSR_CLIP_EN    = 3'd1,
      CSR_CLIP_AX    = 3'd2,
      CSR_CLIP_AY    = 3'd3,
      CSR_CLIP_BX    = 3'd4,
      CSR_CLIP_BY    = 3'd5,
      CSR_FIRST_LINE = 3'd6,
      CSR_LAST_LINE  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_FILL  = 2'd1,
      OP_CSYNC = 2'd2,
      OP_VSYNC = 2'd3
   } op_kind_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PIX_WR,
      BK_FILL_ROW,
      BK_FILL_WR,
      BK_SCAN
   } back_state_type;

   // One classified command as it sits in the queue.
   typedef struct packed {
      op_kind_type              kind;
      logic [ADDR_W-1:0]        addr;
      logic [2:0]               bit_sel;
      logic                     ink;
      logic signed [LIN_W-1:0]  base;
      logic [RUN_W-1:0]         run;
      logic [SIZE_W-1:0]        rows;
   } op_type;

   typedef struct packed {
      logic [LINE_W-1:0] first_line;
      logic [LINE_W-1:0] last_line;
   } window_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_byte;
      logic [ROW_W-1:0] row_index;
      logic             last_byte;
   } rsp_item_type;

endpackage

`default_nettype wire

### rtl/mfbosd_front.sv
// Front half: register file, command intake and pixel/fill classification.
// Depends on mfbosd_pkg; feeds mfbosd_queue.
`default_nettype none

module mfbosd_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [mfbosd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [mfbosd_pkg::REQ_USER_W-1:0]    req_tuser,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mfbosd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mfbosd_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire mfbosd_pkg::back_status_type          back_status,
   input  wire logic                                 q_full,
   output logic                                      q_push,
   output mfbosd_pkg::op_type                        q_push_op,
   output mfbosd_pkg::window_type                    window
);
   import mfbosd_pkg::*;

   localparam logic signed [COORD_W:0] FW    = (COORD_W+1)'(FRAME_WIDTH);
   localparam logic signed [COORD_W:0] FH    = (COORD_W+1)'(FRAME_HEIGHT);
   localparam logic signed [COORD_W:0] FW_M1 = (COORD_W+1)'(FRAME_WIDTH - 1);
   localparam logic signed [COORD_W:0] FH_M1 = (COORD_W+1)'(FRAME_HEIGHT - 1);
   localparam logic signed [COORD_W:0] ROUND = (COORD_W+1)'(7);

   logic [1:0]                rotation_ff, rotation_in;
   logic                      clip_en_ff, clip_en_in;
   logic signed [COORD_W-1:0] clip_ax_ff, clip_ax_in, clip_ay_ff, clip_ay_in;
   logic signed [COORD_W-1:0] clip_bx_ff, clip_bx_in, clip_by_ff, clip_by_in;
   logic [LINE_W-1:0]         first_line_ff, first_line_in, last_line_ff, last_line_in;

   cmd_type                   cmd;
   logic signed [COORD_W-1:0] px, py;
   logic signed [COORD_W:0]   px_w, py_w, lw, lh, sx, sy, px_adj, xdiv;
   logic signed [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;
   logic                      in_frame, clip_ok, accepted;
   logic [SIZE_W-1:0]         rect_w, rect_h;
   logic [SIZE_W:0]           w_plus;
   logic                      ink;

   // Register writes.
   always_comb begin
      rotation_in   = rotation_ff;
      clip_en_in    = clip_en_ff;
      clip_ax_in    = clip_ax_ff;
      clip_ay_in    = clip_ay_ff;
      clip_bx_in    = clip_bx_ff;
      clip_by_in    = clip_by_ff;
      first_line_in = first_line_ff;
      last_line_in  = last_line_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROTATION:   rotation_in   = csr_data[1:0];
            CSR_CLIP_EN:    clip_en_in    = csr_data[0];
            CSR_CLIP_AX:    clip_ax_in    = csr_data;
            CSR_CLIP_AY:    clip_ay_in    = csr_data;
            CSR_CLIP_BX:    clip_bx_in    = csr_data;
            CSR_CLIP_BY:    clip_by_in    = csr_data;
            CSR_FIRST_LINE: first_line_in = csr_data[LINE_W-1:0];
            CSR_LAST_LINE:  last_line_in  = csr_data[LINE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff   <= '0;
         clip_en_ff    <= 1'b0;
         clip_ax_ff    <= '0;
         clip_ay_ff    <= '0;
         clip_bx_ff    <= '0;
         clip_by_ff    <= '0;
         first_line_ff <= FIRST_LINE_RST;
         last_line_ff  <= LAST_LINE_RST;
      end else begin
         rotation_ff   <= rotation_in;
         clip_en_ff    <= clip_en_in;
         clip_ax_ff    <= clip_ax_in;
         clip_ay_ff    <= clip_ay_in;
         clip_bx_ff    <= clip_bx_in;
         clip_by_ff    <= clip_by_in;
         first_line_ff <= first_line_in;
         last_line_ff  <= last_line_in;
      end
   end

   assign csr_ready         = 1'b1;
   assign window.first_line = first_line_ff;
   assign window.last_line  = last_line_ff;

   // Unpack the request beat.
   assign cmd    = cmd_type'(req_tuser);
   assign px     = req_tdata[COORD_W-1:0];
   assign py     = req_tdata[2*COORD_W-1:COORD_W];
   assign rect_w = req_tdata[2*COORD_W+SIZE_W-1:2*COORD_W];
   assign rect_h = req_tdata[2*COORD_W+2*SIZE_W-1:2*COORD_W+SIZE_W];
   assign ink    = req_tdata[2*COORD_W+2*SIZE_W];
   assign px_w   = {px[COORD_W-1], px};
   assign py_w   = {py[COORD_W-1], py};

   // Pixel write: bounds in the rotated frame, clip box, then rotation into store space.
   always_comb begin
      lw       = rotation_ff[0] ? FH : FW;
      lh       = rotation_ff[0] ? FW : FH;
      in_frame = !px[COORD_W-1] && !py[COORD_W-1] && (px_w < lw) && (py_w < lh);
      x_lo     = (clip_ax_ff < clip_bx_ff) ? clip_ax_ff : clip_bx_ff;
      x_hi     = (clip_ax_ff < clip_bx_ff) ? clip_bx_ff : clip_ax_ff;
      y_lo     = (clip_ay_ff < clip_by_ff) ? clip_ay_ff : clip_by_ff;
      y_hi     = (clip_ay_ff < clip_by_ff) ? clip_by_ff : clip_ay_ff;
      clip_ok  = !clip_en_ff ||
                 ((px >= x_lo) && (px <= x_hi) && (py >= y_lo) && (py <= y_hi));
      unique case (rotation_ff)
         2'd0: begin
            sx = px_w;
            sy = py_w;
         end
         2'd1: begin
            sx = FW_M1 - py_w;
            sy = px_w;
         end
         2'd2: begin
            sx = FW_M1 - px_w;
            sy = FH_M1 - py_w;
         end
         2'd3: begin
            sx = py_w;
            sy = FH_M1 - px_w;
         end
      endcase
   end

   // Rectangle origin: x divided by eight rounding toward zero.
   assign px_adj = px_w + (px[COORD_W-1] ? ROUND : '0);
   assign xdiv   = px_adj >>> 3;
   assign w_plus = {1'b0, rect_w} + (SIZE_W+1)'(7);

   always_comb begin
      q_push_op.addr    = ADDR_W'(sx[COORD_W:3]) + ADDR_W'(sy * ROW_BYTES);
      q_push_op.bit_sel = sx[2:0];
      q_push_op.ink     = ink;
      q_push_op.base    = LIN_W'(xdiv) + LIN_W'(py_w * ROW_BYTES);
      q_push_op.run     = w_plus[SIZE_W:3];
      q_push_op.rows    = rect_h;
      unique case (cmd)
         CMD_PIXEL: q_push_op.kind = OP_PIXEL;
         CMD_FILL:  q_push_op.kind = OP_FILL;
         CMD_CSYNC: q_push_op.kind = OP_CSYNC;
         CMD_VSYNC: q_push_op.kind = OP_VSYNC;
      endcase
   end

   assign req_tready = !q_full && !back_status.clearing;
   assign accepted   = req_tvalid && req_tready;
   // Pixel writes that miss the frame or the clip box are dropped here.
   assign q_push     = accepted && ((cmd != CMD_PIXEL) || (in_frame && clip_ok));

endmodule

`default_nettype wire

### rtl/mfbosd_queue.sv
// Short first-in first-out queue of classified commands.
// Depends on mfbosd_pkg; sits between mfbosd_front and mfbosd_back.
`default_nettype none

module mfbosd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mfbosd_pkg::op_type push_op,
   input  wire logic               pop,
   output mfbosd_pkg::op_type      head_op,
   output logic                    empty,
   output logic                    full
);
   import mfbosd_pkg::*;

   op_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

### rtl/mfbosd_back.sv
// Back half: frame store memory, clearing pass, pixel and fill writes, line scan-out.
// Depends on mfbosd_pkg; drains mfbosd_queue and drives the result channel.
`default_nettype none

module mfbosd_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_empty,
   input  wire mfbosd_pkg::op_type                q_head,
   output logic                                   q_pop,
   input  wire mfbosd_pkg::window_type            window,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [mfbosd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,
   output mfbosd_pkg::back_status_type            status
);
   import mfbosd_pkg::*;

   localparam logic signed [LIN_W-1:0] STORE_END = LIN_W'(STORE_BYTES);
   localparam logic signed [LIN_W-1:0] ROW_STEP  = LIN_W'(ROW_BYTES);

   back_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [LCNT_W-1:0]       line_ff, line_in;

   // Current operation.
   logic [ADDR_W-1:0]       pix_addr_ff, pix_addr_in;
   logic [2:0]              pix_bit_ff, pix_bit_in;
   logic                    ink_ff, ink_in;
   logic signed [LIN_W-1:0] cur_lo_ff, cur_lo_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [SIZE_W-1:0]       rows_left_ff, rows_left_in;
   logic [ADDR_W:0]         done_hi_ff, done_hi_in;
   logic [ADDR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W:0]         wr_end_ff, wr_end_in;
   logic [ADDR_W-1:0]       scan_base_ff, scan_base_in;
   logic [K_W-1:0]          scan_k_ff, scan_k_in;
   logic [ROW_W-1:0]        scan_row_ff, scan_row_in;

   // Memory ports.
   logic [PIX_W-1:0]        store_mem [STORE_BYTES];
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [PIX_W-1:0]        mem_wdata, rd_data_ff;

   // Scan read tracking and the two-entry result buffer.
   logic                    scan_issue, pend_ff, pend_in, pend_last_ff;
   logic [ROW_W-1:0]        pend_row_ff;
   rsp_item_type            obuf_ff [2];
   logic                    owr_ff, ord_ff;
   logic [1:0]              occ_ff, occ_in;
   logic                    opop, can_issue;

   // Fill row window and sync decode.
   logic signed [LIN_W-1:0] row_hi, row_end, row_start, done_hi_s;
   logic [LCNT_W-1:0]       line_next, sync_row;
   logic                    sync_vis;
   logic [PIX_W-1:0]        bit_mask;

   assign status.clearing = (state_ff == BK_CLEAR);

   always_comb begin
      row_hi    = cur_lo_ff + LIN_W'(run_ff);
      row_end   = (row_hi > STORE_END) ? STORE_END : row_hi;
      done_hi_s = LIN_W'(done_hi_ff);
      row_start = (cur_lo_ff > done_hi_s) ? cur_lo_ff : done_hi_s;
      line_next = line_ff + LCNT_W'(1);
      sync_row  = line_next - LCNT_W'(window.first_line);
      sync_vis  = (line_next >= LCNT_W'(window.first_line)) &&
                  (line_next <= LCNT_W'(window.last_line)) &&
                  (sync_row < LCNT_W'(FRAME_HEIGHT));
      bit_mask  = MSB_MASK >> pix_bit_ff;
   end

   assign opop      = rsp_tvalid && rsp_tready;
   assign can_issue = ({1'b0, occ_ff} + {2'b0, pend_ff}) < (3'd2 + {2'b0, opop});

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      line_in      = line_ff;
      pix_addr_in  = pix_addr_ff;
      pix_bit_in   = pix_bit_ff;
      ink_in       = ink_ff;
      cur_lo_in    = cur_lo_ff;
      run_in       = run_ff;
      rows_left_in = rows_left_ff;
      done_hi_in   = done_hi_ff;
      wr_ptr_in    = wr_ptr_ff;
      wr_end_in    = wr_end_ff;
      scan_base_in = scan_base_ff;
      scan_k_in    = scan_k_ff;
      scan_row_in  = scan_row_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      scan_issue   = 1'b0;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               unique case (q_head.kind)
                  OP_PIXEL: begin
                     // Read the byte now, merge the bit next cycle.
                     mem_re      = 1'b1;
                     mem_raddr   = q_head.addr;
                     pix_addr_in = q_head.addr;
                     pix_bit_in  = q_head.bit_sel;
                     ink_in      = q_head.ink;
                     state_in    = BK_PIX_WR;
                  end
                  OP_FILL: begin
                     cur_lo_in    = q_head.base;
                     run_in       = q_head.run;
                     rows_left_in = (q_head.run == '0) ? '0 : q_head.rows;
                     done_hi_in   = '0;
                     ink_in       = q_head.ink;
                     state_in     = BK_FILL_ROW;
                  end
                  OP_CSYNC: begin
                     line_in = line_next;
                     if (sync_vis) begin
                        scan_base_in = ADDR_W'(sync_row * ROW_BYTES);
                        scan_row_in  = sync_row[ROW_W-1:0];
                        scan_k_in    = '0;
                        state_in     = BK_SCAN;
                     end
                  end
                  OP_VSYNC: begin
                     line_in = '0;
                  end
               endcase
            end
         end
         BK_PIX_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr_ff;
            mem_wdata = ink_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
            state_in  = BK_IDLE;
         end
         BK_FILL_ROW: begin
            if ((rows_left_ff == '0) || (cur_lo_ff >= STORE_END)) begin
               state_in = BK_IDLE;
            end else if (row_start < row_end) begin
               wr_ptr_in = ADDR_W'(row_start);
               wr_end_in = (ADDR_W+1)'(row_end);
               state_in  = BK_FILL_WR;
            end else begin
               rows_left_in = rows_left_ff - SIZE_W'(1);
               cur_lo_in    = cur_lo_ff + ROW_STEP;
            end
         end
         BK_FILL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_ff;
            mem_wdata = ink_ff ? BYTE_ONES : '0;
            wr_ptr_in = wr_ptr_ff + ADDR_W'(1);
            if (({1'b0, wr_ptr_ff} + (ADDR_W+1)'(1)) == wr_end_ff) begin
               done_hi_in   = wr_end_ff;
               rows_left_in = rows_left_ff - SIZE_W'(1);
               cur_lo_in    = cur_lo_ff + ROW_STEP;
               state_in     = BK_FILL_ROW;
            end
         end
         BK_SCAN: begin
            if (can_issue) begin
               mem_re     = 1'b1;
               mem_raddr  = scan_base_ff + ADDR_W'(scan_k_ff);
               scan_issue = 1'b1;
               scan_k_in  = scan_k_ff + K_W'(1);
               if (scan_k_ff == K_W'(SCAN_N - 1)) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign pend_in = scan_issue;

   always_comb begin
      occ_in = occ_ff + 2'(pend_ff) - 2'(opop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_CLEAR;
         clr_addr_ff <= '0;
         line_ff     <= '0;
         pend_ff     <= 1'b0;
         occ_ff      <= '0;
         owr_ff      <= 1'b0;
         ord_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         line_ff     <= line_in;
         pend_ff     <= pend_in;
         occ_ff      <= occ_in;
         if (pend_ff) begin
            owr_ff <= !owr_ff;
         end
         if (opop) begin
            ord_ff <= !ord_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_addr_ff  <= pix_addr_in;
      pix_bit_ff   <= pix_bit_in;
      ink_ff       <= ink_in;
      cur_lo_ff    <= cur_lo_in;
      run_ff       <= run_in;
      rows_left_ff <= rows_left_in;
      done_hi_ff   <= done_hi_in;
      wr_ptr_ff    <= wr_ptr_in;
      wr_end_ff    <= wr_end_in;
      scan_base_ff <= scan_base_in;
      scan_k_ff    <= scan_k_in;
      scan_row_ff  <= scan_row_in;
      if (scan_issue) begin
         pend_last_ff <= (scan_k_ff == K_W'(SCAN_N - 1));
         pend_row_ff  <= scan_row_ff;
      end
      if (pend_ff) begin
         obuf_ff[owr_ff] <= '{pixel_byte: rd_data_ff, row_index: pend_row_ff,
                              last_byte: pend_last_ff};
      end
   end

   // Frame store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   assign rsp_tvalid = (occ_ff != '0);
   assign rsp_tdata  = {obuf_ff[ord_ff].row_index, obuf_ff[ord_ff].pixel_byte};
   assign rsp_tlast  = obuf_ff[ord_ff].last_byte;

endmodule

`default_nettype wire

### rtl/mono_framebuffer_osd_scanout_top.sv
// Top level of the 1-bit-per-pixel frame store with on-screen-display scan-out.
// Depends on mfbosd_pkg, mfbosd_front, mfbosd_queue and mfbosd_back.
//
// Channel  Dir  Handshake              Beat contents
// req_     in   req_tvalid/req_tready  tuser: cmd; tdata: pos_x, pos_y, rect_w, rect_h, ink
// rsp_     out  rsp_tvalid/rsp_tready  tdata: pixel_byte, row_index; tlast: last_byte
// csr_     in   csr_valid/csr_ready    csr_index: register, csr_data: value
//
// After reset the store is swept to zero, one byte a cycle; no request beat is taken
// until that pass is over. Configuration writes are taken at any time.
// A pixel write in the back half reads the byte, then merges the bit and writes it back.
// A composite sync that sends a row is dispatched, then reads the 32 bytes of the row
// in order, paced by the single read port of the store; a result channel that is not
// ready stalls the scan through a two-entry output buffer.
// A rectangle fill is dispatched, then visits each row up to the end of the store and
// writes the store bytes of its run one at a time, then finishes; bytes that the run of the
// row above has already covered are not written again.
// The four-entry command queue lets the request side run ahead while the back half works.
`default_nettype none

module mono_framebuffer_osd_scanout_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0: pos_x[15:0], pos_y[31:16], rect_w[47:32], rect_h[63:48],
   // ink[64], zero padding up to bit 71.
   input  wire logic [mfbosd_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: cmd[1:0].
   input  wire logic [mfbosd_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // Fields from bit 0: pixel_byte[7:0], row_index[15:8].
   output logic [mfbosd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mfbosd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mfbosd_pkg::CSR_DATA_W-1:0] csr_data
);
   import mfbosd_pkg::*;

   op_type          q_push_op, q_head;
   logic            q_push, q_pop, q_empty, q_full;
   window_type      window;
   back_status_type back_status;

   // The front half checks and classifies each beat, then queues it unless it is a dropped pixel write.
   mfbosd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .back_status (back_status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_op   (q_push_op),
      .window      (window)
   );

   mfbosd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .pop     (q_pop),
      .head_op (q_head),
      .empty   (q_empty),
      .full    (q_full)
   );

   // The back half owns the store and carries out one command at a time.
   mfbosd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .window     (window),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (back_status)
   );

   // The front half never offers a command to a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   // While the clearing pass runs, nothing enters and nothing leaves.
   a_quiet_while_clearing: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> (!req_tready && !rsp_tvalid))
      else $error("traffic during the clearing pass");

   // Every reset starts a fresh clearing pass.
   a_reset_starts_clear: assert property (@(posedge clock)
      reset |=> back_status.clearing)
      else $error("clearing pass not started after reset");

endmodule

`default_nettype wire

### tb/mono_framebuffer_osd_scanout_top_tb.sv
// Self-checking testbench for the monochrome frame store with scan-out.
// Depends on mfbosd_pkg and mono_framebuffer_osd_scanout_top; reads no files.
// A shadow copy of the store and line counter predicts every row byte sent.

module mono_framebuffer_osd_scanout_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfbosd_pkg::*;

   // Generous ceiling on the whole run, which covers the clearing pass, the large
   // fills and the stalls.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   // Request tdata layout, first field in the lowest bits.
   typedef struct packed {
      logic [6:0]         pad;
      logic               ink;
      logic [SIZE_W-1:0]  rect_h;
      logic [SIZE_W-1:0]  rect_w;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_x;
   } req_payload_type;

   // Shadow of the frame store, the line counter and the registers. Every accepted
   // request beat updates it, and each sent row byte is checked against it in order.
   class framebuffer_shadow;
      logic [PIX_W-1:0]  store [STORE_BYTES];
      logic [LCNT_W-1:0] line_count;
      logic [1:0]        rotation;
      logic              clip_en;
      shortint           clip_ax, clip_ay, clip_bx, clip_by;
      logic [LINE_W-1:0] first_line, last_line;
      rsp_item_type      pending_row_bytes [$];
      int unsigned       failures;
      int unsigned       drain_cycles;

      function new();
         foreach (store[a]) store[a] = '0;
         line_count   = '0;
         rotation     = '0;
         clip_en      = 1'b0;
         clip_ax      = 0;
         clip_ay      = 0;
         clip_bx      = 0;
         clip_by      = 0;
         first_line   = FIRST_LINE_RST;
         last_line    = LAST_LINE_RST;
         failures     = 0;
         drain_cycles = 0;
      endfunction

      function int pending();
         return pending_row_bytes.size();
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_ROTATION:   rotation   = value[1:0];
            CSR_CLIP_EN:    clip_en    = value[0];
            CSR_CLIP_AX:    clip_ax    = value;
            CSR_CLIP_AY:    clip_ay    = value;
            CSR_CLIP_BX:    clip_bx    = value;
            CSR_CLIP_BY:    clip_by    = value;
            CSR_FIRST_LINE: first_line = value[LINE_W-1:0];
            CSR_LAST_LINE:  last_line  = value[LINE_W-1:0];
            default: ;
         endcase
      endfunction

      function void plot_pixel(int x, int y, bit on);
         int lw, lh, lo_x, hi_x, lo_y, hi_y, sx, sy, addr;
         lw = rotation[0] ? FRAME_HEIGHT : FRAME_WIDTH;
         lh = rotation[0] ? FRAME_WIDTH : FRAME_HEIGHT;
         if (x < 0 || y < 0 || x >= lw || y >= lh) return;
         if (clip_en) begin
            // The corners may come in either order.
            lo_x = (clip_ax < clip_bx) ? clip_ax : clip_bx;
            hi_x = (clip_ax < clip_bx) ? clip_bx : clip_ax;
            lo_y = (clip_ay < clip_by) ? clip_ay : clip_by;
            hi_y = (clip_ay < clip_by) ? clip_by : clip_ay;
            if (x < lo_x || x > hi_x || y < lo_y || y > hi_y) return;
         end
         case (rotation)
            2'd1: begin
               sx = FRAME_WIDTH - 1 - y;
               sy = x;
            end
            2'd2: begin
               sx = FRAME_WIDTH - 1 - x;
               sy = FRAME_HEIGHT - 1 - y;
            end
            2'd3: begin
               sx = y;
               sy = FRAME_HEIGHT - 1 - x;
            end
            default: begin
               sx = x;
               sy = y;
            end
         endcase
         if (sx < 0 || sy < 0 || sx >= FRAME_WIDTH || sy >= FRAME_HEIGHT) return;
         addr = sx / 8 + sy * ROW_BYTES;
         if (on) store[addr] = store[addr] | (MSB_MASK >> sx[2:0]);
         else store[addr] = store[addr] & ~(MSB_MASK >> sx[2:0]);
      endfunction

      // Returns the number of store bytes written.
      function int unsigned fill_bytes(int x, int y, int unsigned w, int unsigned h, bit on);
         longint run, base, lo, hi, i, a;
         int unsigned written;
         written = 0;
         run = (longint'(w) + 7) / 8;
         if (run == 0) return 0;
         for (i = 0; i < h; i++) begin
            // Division truncates towards zero, so runs may start in the row above.
            base = longint'(x / 8) + (longint'(y) + i) * ROW_BYTES;
            lo = base;
            hi = base + run;
            if (lo >= STORE_BYTES) break;
            if (lo < 0) lo = 0;
            if (hi > STORE_BYTES) hi = STORE_BYTES;
            for (a = lo; a < hi; a++) begin
               store[a] = on ? BYTE_ONES : '0;
               written++;
            end
         end
         return written;
      endfunction

      function void note_request(logic [REQ_USER_W-1:0] user, logic [REQ_DATA_W-1:0] data);
         req_payload_type p;
         rsp_item_type e;
         int row, k;
         int unsigned cost;
         p = data;
         cost = 4;
         case (cmd_type'(user))
            CMD_PIXEL: plot_pixel(p.pos_x, p.pos_y, p.ink);
            CMD_FILL:  cost = 4 + p.rect_h + fill_bytes(p.pos_x, p.pos_y, p.rect_w, p.rect_h,
                                                         p.ink);
            CMD_VSYNC: line_count = '0;
            CMD_CSYNC: begin
               line_count++;
               if (line_count >= first_line && line_count <= last_line) begin
                  row = int'(line_count) - int'(first_line);
                  // Rows past the bottom of the store send nothing.
                  if (row < FRAME_HEIGHT) begin
                     for (k = 0; k < SCAN_N; k++) begin
                        e.pixel_byte = store[row * ROW_BYTES + k];
                        e.row_index  = row[ROW_W-1:0];
                        e.last_byte  = (k == SCAN_N - 1);
                        pending_row_bytes.push_back(e);
                     end
                     cost = 0;
                  end
               end
            end
            default: ;
         endcase
         // Work queued since the last sent row; bounds how long the block may stay busy.
         drain_cycles = (cost == 0) ? 0 : drain_cycles + cost;
      endfunction

      function void check_row_byte(logic [RSP_DATA_W-1:0] data, logic tlast_bit);
         rsp_item_type want;
         if (pending_row_bytes.size() == 0) begin
            $error("row byte %h (last %b) arrived with none expected", data, tlast_bit);
            failures++;
            return;
         end
         want = pending_row_bytes.pop_front();
         if (data[PIX_W-1:0] !== want.pixel_byte) begin
            $error("pixel_byte: expected %h, got %h", want.pixel_byte, data[PIX_W-1:0]);
            failures++;
         end
         if (data[PIX_W +: ROW_W] !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, data[PIX_W +: ROW_W]);
            failures++;
         end
         if (tlast_bit !== want.last_byte) begin
            $error("last_byte: expected %b, got %b", want.last_byte, tlast_bit);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   framebuffer_shadow shadow;
   int unsigned       burst_left;
   int unsigned       cycle_count;

   mono_framebuffer_osd_scanout_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Both monitors sample at the rising edge, before the block's registers move.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) shadow.note_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_row_byte(rsp_tdata, rsp_tlast);
   end

   // The receiver switches at random between stall patterns: always ready, a coin
   // toss, ready on a sparse regular tick, or long runs on and off in turn. The slow patterns
   // fill the output buffer and back-pressure the scan in the middle of a row.
   initial begin : receiver
      int unsigned rx_tick, rx_mode;
      rx_tick = 0;
      rx_mode = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rx_tick++;
         if (rx_tick % 128 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = $urandom_range(0, 1);
            2: rsp_tready = (rx_tick % 8 == 0);
            default: rsp_tready = rx_tick[4];
         endcase
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Presents one request beat and holds it until it is taken. The sender works in
   // bursts of random length; before each burst it may drop tvalid for a random gap.
   // Called and returns at a falling edge, leaving tvalid high for the next beat.
   task automatic send_op(cmd_type cmd, int x, int y, int w, int h, bit ink);
      req_payload_type p;
      int unsigned gap;
      p        = '0;
      p.pos_x  = 16'(x);
      p.pos_y  = 16'(y);
      p.rect_w = 16'(w);
      p.rect_h = 16'(h);
      p.ink    = ink;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = p;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Sync beats ignore their data fields, so they carry random noise there.
   task automatic send_sync(cmd_type cmd);
      send_op(cmd, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
   endtask

   task automatic send_draw();
      int unsigned pick;
      bit ink;
      pick = $urandom_range(0, 99);
      ink  = ($urandom_range(0, 9) < 7);
      if (pick < 10) begin
         send_op(CMD_PIXEL, $urandom, $urandom, $urandom, $urandom, ink);
      end else if (pick < 25) begin
         // Aim just inside or just outside a clip corner.
         if (pick[0])
            send_op(CMD_PIXEL, shadow.clip_ax + $urandom_range(0, 2) - 1,
                    shadow.clip_ay + $urandom_range(0, 2) - 1, $urandom, $urandom, ink);
         else
            send_op(CMD_PIXEL, shadow.clip_bx + $urandom_range(0, 2) - 1,
                    shadow.clip_by + $urandom_range(0, 2) - 1, $urandom, $urandom, ink);
      end else if (pick < 70) begin
         send_op(CMD_PIXEL, int'($urandom_range(0, 271)) - 8, int'($urandom_range(0, 271)) - 8,
                 $urandom, $urandom, ink);
      end else begin
         send_op(CMD_FILL, int'($urandom_range(0, 319)) - 40, int'($urandom_range(0, 299)) - 20,
                 $urandom_range(0, 96), $urandom_range(0, 12), ink);
      end
   endtask

   // Mostly drawing and short runs of composite syncs after a vertical sync, so that
   // freshly drawn rows are sent back; one pick in ten sends a random command.
   task automatic random_phase(int items);
      int sent, run_len;
      int unsigned pick;
      sent = 0;
      send_sync(CMD_VSYNC);
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_draw();
            sent++;
         end else if (pick < 85) begin
            run_len = $urandom_range(1, 6);
            repeat (run_len) send_sync(CMD_CSYNC);
            sent += run_len;
         end else if (pick < 90) begin
            send_sync(CMD_VSYNC);
            sent++;
         end else begin
            // Fills among these stay small enough to keep the run short.
            send_op(cmd_type'($urandom_range(0, 3)), $urandom, $urandom,
                    $urandom_range(0, 2047), $urandom_range(0, 7), $urandom_range(0, 1));
            sent++;
         end
      end
   endtask

   // Waits until every expected row byte has come back, then lets the block finish
   // any fills or pixel writes still queued behind the last sent row.
   task automatic settle();
      int unsigned hold;
      req_tvalid = 1'b0;
      burst_left = 0;
      while (shadow.pending() != 0) @(posedge clock);
      hold = 2 * shadow.drain_cycles + 64;
      repeat (hold) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pad_noise(int value, int width);
      logic [CSR_DATA_W-1:0] keep;
      keep = (CSR_DATA_W'(1) << width) - 1'b1;
      return (CSR_DATA_W'($urandom) & ~keep) | (CSR_DATA_W'(value) & keep);
   endfunction

   // Leaves csr_valid high so that back-to-back writes never glitch it.
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      shadow.set_register(idx, value);
      @(negedge clock);
   endtask

   // Writes all eight registers; unused upper bits of the narrow ones carry noise.
   task automatic apply_setting(int rot, int clip, int ax, int ay, int bx, int by,
                                int first_ln, int last_ln);
      csr_write(CSR_ROTATION, pad_noise(rot, 2));
      csr_write(CSR_CLIP_EN, pad_noise(clip, 1));
      csr_write(CSR_CLIP_AX, CSR_DATA_W'(ax));
      csr_write(CSR_CLIP_AY, CSR_DATA_W'(ay));
      csr_write(CSR_CLIP_BX, CSR_DATA_W'(bx));
      csr_write(CSR_CLIP_BY, CSR_DATA_W'(by));
      csr_write(CSR_FIRST_LINE, pad_noise(first_ln, LINE_W));
      csr_write(CSR_LAST_LINE, pad_noise(last_ln, LINE_W));
      csr_valid = 1'b0;
   endtask

   initial begin : stimulus
      int ph, first_ln;
      shadow     = new();
      burst_left = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats with the registers at their reset values. The first two fills
      // are the largest the run uses: one with the tallest rectangle, whose rows mostly
      // lie above the store and are skipped, and one with the widest.
      send_op(CMD_FILL, -32768, -32768, 1, 65535, 1'b1);
      send_op(CMD_FILL, 32767, -200, 65535, 1, 1'b0);
      // A run that starts left of column zero spills back into the row above.
      send_op(CMD_FILL, -9, 1, 16, 2, 1'b1);
      // A run past the right edge spills into the next row.
      send_op(CMD_FILL, 250, 3, 24, 1, 1'b1);
      // A small negative origin truncates to byte column zero.
      send_op(CMD_FILL, -7, 2, 9, 1, 1'b0);
      // Zero width and zero height write nothing.
      send_op(CMD_FILL, 5, 0, 0, 5, 1'b1);
      send_op(CMD_FILL, 5, 0, 8, 0, 1'b1);
      send_op(CMD_PIXEL, 0, 0, 0, 0, 1'b1);
      send_op(CMD_PIXEL, 255, 255, 65535, 65535, 1'b1);
      send_op(CMD_PIXEL, 7, 0, 0, 0, 1'b1);
      send_op(CMD_PIXEL, 256, 3, 0, 0, 1'b1);
      send_op(CMD_PIXEL, 3, 256, 0, 0, 1'b1);
      send_op(CMD_PIXEL, -1, 0, 0, 0, 1'b1);
      send_op(CMD_PIXEL, 32767, -32768, 0, 0, 1'b1);
      send_op(CMD_PIXEL, 0, 0, 0, 0, 1'b0);
      // With the reset window, rows zero to three go out on lines 27 to 30.
      send_sync(CMD_VSYNC);
      repeat (30) send_sync(CMD_CSYNC);
      settle();

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0: apply_setting(1, 0, $urandom, $urandom, $urandom, $urandom, 0, 1023);
            // Corners given high before low.
            1: apply_setting(2, 1, 200, 250, 10, 5, 5, 40);
            2: apply_setting(3, 1, -32768, -32768, 32767, 32767, 1, 20);
            // A one-pixel clip box, and a window whose first line lies past its last.
            3: apply_setting(0, 1, 100, 100, 100, 100, 10, 3);
            4: apply_setting(1, 1, 32767, 32767, -32768, -32768, 1023, 0);
            default: begin
               first_ln = $urandom_range(0, 8);
               apply_setting($urandom_range(0, 3), $urandom_range(0, 1),
                             int'($urandom_range(0, 299)) - 20, int'($urandom_range(0, 299)) - 20,
                             int'($urandom_range(0, 299)) - 20, int'($urandom_range(0, 299)) - 20,
                             first_ln, first_ln + $urandom_range(0, 60));
            end
         endcase
         random_phase(12);
         settle();
      end

      // A full frame sweep sends every store row once; the two extra lines fall past
      // the bottom of the store and send nothing.
      apply_setting($urandom_range(0, 3), 0, 0, 0, 0, 0, 1, 1023);
      repeat (20) send_draw();
      send_sync(CMD_VSYNC);
      repeat (FRAME_HEIGHT + 2) send_sync(CMD_CSYNC);
      settle();

      if (shadow.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### mono_framebuffer_osd_scanout_top.f
rtl/mfbosd_pkg.sv
rtl/mfbosd_front.sv
rtl/mfbosd_queue.sv
rtl/mfbosd_back.sv
rtl/mono_framebuffer_osd_scanout_top.sv
tb/mono_framebuffer_osd_scanout_top_tb.sv
